[rtl/bsrf_pkg.sv]
`default_nettype none

package bsrf_pkg;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned TOT_W  = 32;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 112;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);
  localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_PEEK  = 3'd1,
    OP_POP   = 3'd2,
    OP_READ  = 3'd3,
    OP_END   = 3'd4
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  // Packed so that the last field, accepted, sits in the lowest bits.
  typedef struct packed {
    logic [TOT_W-1:0] total_read;
    logic [TOT_W-1:0] total_written;
    logic             at_eof;
    logic             ended;
    logic [CNT_W-1:0] space_left;
    logic [CNT_W-1:0] fill_level;
    logic [CNT_W-1:0] popped;
    logic             read_valid;
    logic [7:0]       read_data;
    logic             accepted;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

[rtl/byte_stream_ring_fifo.sv]
// Byte stream ring FIFO.
// Each transaction on the s_axis channel is one operation: write a byte, peek at
// an offset from the head, pop a number of bytes, read one byte, or end input.
// The opcode travels in s_axis_tuser; the operands travel in s_axis_tdata.
// Every operation yields exactly one status transaction on the m_axis channel.
// Write, pop, end of input and unused opcodes: the result is
// registered at the edge that accepts the operation. Peek and read pass
// through ST_READ, waiting on the registered read of the byte memory.
// The bytes live in a 1024-entry synchronous memory addressed by a head
// pointer and a fill count; the memory is not cleared and needs no init pass.
// The capacity register is written over the cfg channel, which is always
// ready; it is meant to be changed only while the block is idle.
// Reset empties the buffer, clears the ended flag and both totals, and sets
// the capacity to 1024. When the receiver stalls, one finished result waits
// in the output register and a second in a holding register; with both
// occupied, s_axis_tready drops until the receiver takes a result.
`default_nettype none

module byte_stream_ring_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bsrf_pkg::CNT_W-1:0]          cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // data_byte[7:0], offset[17:8], pop_count[33:18], zero fill above.
  input  logic [bsrf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // opcode[2:0].
  input  logic [2:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // accepted[0], read_data[8:1], read_valid[9], popped[20:10],
  // fill_level[31:21], space_left[42:32], ended[43], at_eof[44],
  // total_written[76:45], total_read[108:77], zero fill above.
  output logic [bsrf_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import bsrf_pkg::*;

  logic [CNT_W-1:0]  cap_q;
  logic [ADDR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              done_q, done_d;
  logic [TOT_W-1:0]  wtot_q, wtot_d;
  logic [TOT_W-1:0]  rtot_q, rtot_d;
  state_e            state_q, state_d;
  result_t           stage_q, stage_d;
  result_t           out_q, out_d;
  result_t           pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic              pend_valid_q, pend_valid_d;

  ram_req_t          ram_req;
  logic [7:0]        ram_rdata;

  logic              in_acc;
  op_e               op;
  logic [7:0]        in_byte;
  logic [ADDR_W-1:0] in_off;
  logic [15:0]       in_cnt;
  logic [CNT_W-1:0]  eff_cap;
  logic [CNT_W-1:0]  n_pop;
  logic              is_read_op;
  result_t           status;
  result_t           res_d;
  logic              res_en;
  logic              out_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE) && !pend_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign op            = op_e'(s_axis_tuser);
  assign in_byte       = s_axis_tdata[7:0];
  assign in_off        = s_axis_tdata[17:8];
  assign in_cnt        = s_axis_tdata[33:18];
  assign eff_cap       = (cap_q > CAP_MAX) ? CAP_MAX : cap_q;
  assign is_read_op    = (op == OP_PEEK) || (op == OP_READ);

  bsrf_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    head_d  = head_q;
    fill_d  = fill_q;
    done_d  = done_q;
    wtot_d  = wtot_q;
    rtot_d  = rtot_q;
    ram_req = '0;
    status  = '0;
    n_pop   = '0;
    if (in_acc) begin
      case (op)
        OP_WRITE: begin
          if (!done_q && (fill_q < eff_cap)) begin
            ram_req.we      = 1'b1;
            ram_req.waddr   = head_q + fill_q[ADDR_W-1:0];
            ram_req.wdata   = in_byte;
            fill_d          = fill_q + CNT_W'(1);
            wtot_d          = wtot_q + TOT_W'(1);
            status.accepted = 1'b1;
          end
        end
        OP_PEEK: begin
          if ({1'b0, in_off} < fill_q) begin
            ram_req.re        = 1'b1;
            ram_req.raddr     = head_q + in_off;
            status.read_valid = 1'b1;
          end
        end
        OP_POP: begin
          n_pop = ({5'b0, fill_q} < in_cnt) ? fill_q : in_cnt[CNT_W-1:0];
        end
        OP_READ: begin
          if (fill_q != '0) begin
            ram_req.re        = 1'b1;
            ram_req.raddr     = head_q;
            status.read_valid = 1'b1;
            n_pop             = CNT_W'(1);
          end
        end
        OP_END: begin
          done_d = 1'b1;
        end
        default: begin
        end
      endcase
      head_d = head_q + n_pop[ADDR_W-1:0];
      fill_d = fill_d - n_pop;
      rtot_d = rtot_q + TOT_W'(n_pop);
    end
    status.popped        = n_pop;
    status.fill_level    = fill_d;
    status.space_left    = (eff_cap > fill_d) ? (eff_cap - fill_d) : '0;
    status.ended         = done_d;
    status.at_eof        = done_d && (fill_d == '0);
    status.total_written = wtot_d;
    status.total_read    = rtot_d;
  end

  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    res_en  = 1'b0;
    res_d   = status;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_read_op) begin
            stage_d = status;
            state_d = ST_READ;
          end else begin
            res_en = 1'b1;
          end
        end
      end
      ST_READ: begin
        res_en          = 1'b1;
        res_d           = stage_q;
        res_d.read_data = stage_q.read_valid ? ram_rdata : 8'h00;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_d        = out_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    pend_valid_d = pend_valid_q;
    if (out_free) begin
      if (pend_valid_q) begin
        out_d        = pend_q;
        out_valid_d  = 1'b1;
        pend_d       = res_d;
        pend_valid_d = res_en;
      end else begin
        out_d       = res_d;
        out_valid_d = res_en;
      end
    end else if (res_en) begin
      pend_d       = res_d;
      pend_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CAP_RESET;
      head_q       <= '0;
      fill_q       <= '0;
      done_q       <= 1'b0;
      wtot_q       <= '0;
      rtot_q       <= '0;
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      head_q       <= head_d;
      fill_q       <= fill_d;
      done_q       <= done_d;
      wtot_q       <= wtot_d;
      rtot_q       <= rtot_d;
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
    out_q   <= out_d;
    pend_q  <= pend_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), out_q};

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CAP_MAX)
    else $error("fill count exceeds the ring depth");

  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("holding register full while output register is empty");

  a_read_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !pend_valid_q)
    else $error("memory read in flight with no free result slot");

  a_write_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ram_req.we) |=> (wtot_q == $past(wtot_q) + TOT_W'(1)))
    else $error("written total did not advance on a stored byte");
`endif

endmodule

`default_nettype wire

[rtl/bsrf_ram.sv]
`default_nettype none

module bsrf_ram (
  input  logic                       clk_i,
  input  bsrf_pkg::ram_req_t         req_i,
  output logic [7:0]                 rdata_o
);
  import bsrf_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
